// ===== sv/ppst_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the pure pursuit tracker.
package ppst_pkg;

  localparam int unsigned WAYPOINT_DEPTH_DEF = 1024;
  localparam int unsigned END_MARGIN_DEF     = 5;

  localparam int unsigned CW         = 54;  // CORDIC x/y datapath width
  localparam int unsigned WB_W       = 20;
  localparam int unsigned LA_W       = 23;
  localparam int unsigned CFG_DATA_W = 23;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned SLOT_W     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD  = 1'b1;

  localparam logic [4:0]  CORDIC_LAST = 5'd30;
  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

  typedef enum logic {
    CORDIC_VECT,
    CORDIC_ROT
  } cordic_mode_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_req_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_NORM,
    C_ITER,
    C_DONE
  } cst_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INI,
    S_INW,
    S_CHK,
    S_Q0,
    S_Q1,
    S_Q2,
    S_Q3,
    S_Q4,
    S_YAW_GO,
    S_YAW_WT,
    S_BR_GO,
    S_BR_WT,
    S_D0,
    S_D1,
    S_D2,
    S_D3,
    S_SIN_GO,
    S_SIN_WT,
    S_MW0,
    S_ST_GO,
    S_ST_WT,
    S_ADV,
    S_SR,
    S_SW,
    S_TGT,
    S_TGW,
    S_EMIT
  } st_e;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      default: v = 32'h00000001;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/ppst_cordic.sv =====
// Shared iterative CORDIC: vectoring mode gives atan2 in binary radians, rotation mode gives sin.
module ppst_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ppst_pkg::cordic_req_t           req_i,
  input  logic signed [ppst_pkg::CW-1:0]  x_i,
  input  logic signed [ppst_pkg::CW-1:0]  y_i,
  input  logic [31:0]                     angle_i,
  output logic                            done_o,
  output logic [31:0]                     z_o,
  output logic signed [ppst_pkg::CW-1:0]  y_o
);
  import ppst_pkg::*;

  localparam logic signed [CW-1:0] LIM_HI = CW'(64'sd1 <<< 49);
  localparam logic signed [CW-1:0] LIM_LO = CW'(64'sd1 <<< 41);

  cst_e               st_q, st_d;
  cordic_mode_e       mode_q, mode_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic [4:0]         i_q, i_d;

  logic signed [CW-1:0] ax, ay, sx, sy;
  logic signed [33:0]   at;
  logic signed [31:0]   s_in, s_fold;
  logic                 k;

  always_comb begin
    ax     = x_q[CW-1] ? -x_q : x_q;
    ay     = y_q[CW-1] ? -y_q : y_q;
    sx     = x_q >>> i_q;
    sy     = y_q >>> i_q;
    at     = signed'({2'b00, atan_entry(i_q)});
    k      = (mode_q == CORDIC_VECT) ? !y_q[CW-1] : z_q[33];
    s_in   = signed'(angle_i);
    if (s_in > 32'sd1073741824 || s_in < -32'sd1073741824) begin
      s_fold = signed'(32'h80000000 - angle_i);
    end else begin
      s_fold = s_in;
    end

    st_d   = st_q;
    mode_d = mode_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    i_d    = i_q;
    done_o = 1'b0;

    case (st_q)
      C_IDLE: begin
        if (req_i.start) begin
          mode_d = req_i.mode;
          i_d    = '0;
          if (req_i.mode == CORDIC_ROT) begin
            x_d  = CW'(signed'({1'b0, CORDIC_GAIN}));
            y_d  = '0;
            z_d  = 34'(s_fold);
            st_d = C_ITER;
          end else if (x_i == '0 && y_i == '0) begin
            z_d  = '0;
            st_d = C_DONE;
          end else if (x_i[CW-1]) begin
            x_d  = -x_i;
            y_d  = -y_i;
            z_d  = 34'sh080000000;
            st_d = C_NORM;
          end else begin
            x_d  = x_i;
            y_d  = y_i;
            z_d  = '0;
            st_d = C_NORM;
          end
        end
      end
      C_NORM: begin
        // scale up until the larger magnitude reaches 2^49
        if (ax >= LIM_HI || ay >= LIM_HI) begin
          st_d = C_ITER;
        end else if (ax < LIM_LO && ay < LIM_LO) begin
          x_d = x_q <<< 8;
          y_d = y_q <<< 8;
        end else begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end
      end
      C_ITER: begin
        if (k) begin
          x_d = x_q + sy;
          y_d = y_q - sx;
          z_d = z_q + at;
        end else begin
          x_d = x_q - sy;
          y_d = y_q + sx;
          z_d = z_q - at;
        end
        if (i_q == CORDIC_LAST) begin
          st_d = C_DONE;
        end else begin
          i_d = i_q + 5'd1;
        end
      end
      C_DONE: begin
        done_o = 1'b1;
        st_d   = C_IDLE;
      end
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= C_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    i_q    <= i_d;
  end

  assign z_o = z_q[31:0];
  assign y_o = y_q;

endmodule

// ===== sv/ppst_isqrt.sv =====
// Bit-pair iterative integer square root, 32 steps of a 64-bit radicand.
module ppst_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] v_i,
  output logic        done_o,
  output logic [31:0] r_o
);
  import ppst_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] v_q, r_q, b_q;
  logic [63:0] t;

  assign t = r_q + b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= v_i;
      r_q <= '0;
      b_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= t) begin
        v_q <= v_q - t;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q[31:0];

endmodule

// ===== sv/pure_pursuit_steering_tracker.sv =====
// Pure pursuit steering tracker: a load item (command 0) appends a waypoint while loading is
// open and the table is not full. A pose item (command 1) closes loading and yields one result;
// it runs through one shared 33x33 multiplier, one iterative CORDIC (three atan2 and one sin)
// and a 32-step square root, which runs again for each waypoint scanned while the target
// advances; a braking pose skips all of these. The block accepts no item while a pose is at
// work; the result register lets the next item in while a result waits.
module pure_pursuit_steering_tracker #(
  parameter int unsigned WAYPOINT_DEPTH = ppst_pkg::WAYPOINT_DEPTH_DEF,
  parameter int unsigned END_MARGIN     = ppst_pkg::END_MARGIN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic signed [31:0]                pos_x_i,
  input  logic signed [31:0]                pos_y_i,
  input  logic signed [15:0]                quat_x_i,
  input  logic signed [15:0]                quat_y_i,
  input  logic signed [15:0]                quat_z_i,
  input  logic signed [15:0]                quat_w_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [15:0]                steer_o,
  output logic                              brake_o,
  output logic [ppst_pkg::SLOT_W-1:0]       target_slot_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ppst_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ppst_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ppst_pkg::*;

  localparam int unsigned AW = $clog2(WAYPOINT_DEPTH);
  localparam int unsigned TW = AW + 1;

  st_e                state_q, state_d;
  logic [TW-1:0]      total_q;
  logic [AW-1:0]      tidx_q;
  logic               loading_q;
  logic [31:0]        tx_q, ty_q;
  logic [WB_W-1:0]    wb_q;
  logic [LA_W-1:0]    la_q;

  logic [31:0]        mem_x [WAYPOINT_DEPTH];
  logic [31:0]        mem_y [WAYPOINT_DEPTH];
  logic [31:0]        rdx_q, rdy_q;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;

  logic signed [31:0] px_q, py_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] p_q, acc1_q, acc2_q;
  logic signed [32:0] dx_q, dy_q;
  logic [31:0]        yaw_q, alpha_q;
  logic [32:0]        d_q, d_c;
  logic signed [31:0] sn_q;
  logic signed [15:0] steer_q, steer_c;
  logic               brake_q, search_q;

  logic               out_valid_q, out_brake_q;
  logic signed [15:0] out_steer_q;
  logic [SLOT_W-1:0]  out_slot_q;

  cordic_req_t        c_req;
  logic signed [CW-1:0] c_x, c_y, c_yo;
  logic [31:0]        c_ang, c_z;
  logic               c_done;
  logic               sq_start, sq_done;
  logic [63:0]        sq_v;
  logic [31:0]        sq_r;

  logic               in_acc, brake_c, has_next, big;
  logic [32:0]        ax, ay;
  logic [31:0]        opx, opy;
  logic signed [33:0] a_ext, a_rnd, a_neg;

  ppst_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (c_req),
    .x_i     (c_x),
    .y_i     (c_y),
    .angle_i (c_ang),
    .done_o  (c_done),
    .z_o     (c_z),
    .y_o     (c_yo)
  );

  ppst_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .v_i     (sq_v),
    .done_o  (sq_done),
    .r_o     (sq_r)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign wr_en       = in_acc && !command_i && loading_q && (total_q < TW'(WAYPOINT_DEPTH));

  assign brake_c  = (32'(total_q) <= 32'(END_MARGIN)) ||
                    (32'(tidx_q) >= 32'(total_q) - 32'(END_MARGIN));
  assign has_next = (TW'(tidx_q) + TW'(1)) < total_q;

  // distance operands: halve both when either magnitude reaches 2^31
  always_comb begin
    ax  = dx_q[32] ? unsigned'(-dx_q) : unsigned'(dx_q);
    ay  = dy_q[32] ? unsigned'(-dy_q) : unsigned'(dy_q);
    big = ax[32] | ax[31] | ay[32] | ay[31];
    opx = big ? ax[32:1] : ax[31:0];
    opy = big ? ay[32:1] : ay[31:0];
    d_c = big ? {sq_r, 1'b0} : {1'b0, sq_r};
  end

  // steer = -round(a / 2^16), saturated
  always_comb begin
    a_ext = 34'(signed'(c_z));
    a_rnd = (a_ext + 34'sd32768) >>> 16;
    a_neg = -a_rnd;
    if (a_neg > 34'sd16384) begin
      steer_c = 16'sd16384;
    end else if (a_neg < -34'sd16384) begin
      steer_c = -16'sd16384;
    end else begin
      steer_c = 16'(a_neg);
    end
  end

  always_comb begin
    state_d    = state_q;
    c_req      = '{start: 1'b0, mode: CORDIC_VECT};
    c_x        = '0;
    c_y        = '0;
    c_ang      = alpha_q;
    mul_a      = '0;
    mul_b      = '0;
    sq_start   = 1'b0;
    sq_v       = 64'(acc1_q + p_q);
    rd_addr    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc && command_i) begin
          state_d = loading_q ? S_INI : S_CHK;
        end
      end
      S_INI:    state_d = S_INW;
      S_INW:    state_d = S_CHK;
      S_CHK:    state_d = brake_c ? S_EMIT : S_Q0;
      S_Q0: begin
        mul_a   = 33'(qw_q);
        mul_b   = 33'(qz_q);
        state_d = S_Q1;
      end
      S_Q1: begin
        mul_a   = 33'(qx_q);
        mul_b   = 33'(qy_q);
        state_d = S_Q2;
      end
      S_Q2: begin
        mul_a   = 33'(qy_q);
        mul_b   = 33'(qy_q);
        state_d = S_Q3;
      end
      S_Q3: begin
        mul_a   = 33'(qz_q);
        mul_b   = 33'(qz_q);
        state_d = S_Q4;
      end
      S_Q4:     state_d = S_YAW_GO;
      S_YAW_GO: begin
        c_req.start = 1'b1;
        c_y         = CW'(acc1_q <<< 1);
        c_x         = CW'(66'sd268435456 - (acc2_q <<< 1));
        state_d     = S_YAW_WT;
      end
      S_YAW_WT: if (c_done) state_d = S_BR_GO;
      S_BR_GO: begin
        c_req.start = 1'b1;
        c_y         = CW'(dy_q);
        c_x         = CW'(dx_q);
        state_d     = S_BR_WT;
      end
      S_BR_WT:  if (c_done) state_d = S_D0;
      S_D0: begin
        mul_a   = signed'({1'b0, opx});
        mul_b   = signed'({1'b0, opx});
        state_d = S_D1;
      end
      S_D1: begin
        mul_a   = signed'({1'b0, opy});
        mul_b   = signed'({1'b0, opy});
        state_d = S_D2;
      end
      S_D2: begin
        sq_start = 1'b1;
        state_d  = S_D3;
      end
      S_D3: begin
        if (sq_done) begin
          if (!search_q) begin
            state_d = S_SIN_GO;
          end else if (d_c < {10'b0, la_q}) begin
            state_d = S_SR;
          end else begin
            state_d = S_TGT;
          end
        end
      end
      S_SIN_GO: begin
        c_req   = '{start: 1'b1, mode: CORDIC_ROT};
        state_d = S_SIN_WT;
      end
      S_SIN_WT: if (c_done) state_d = S_MW0;
      S_MW0: begin
        mul_a   = signed'({13'b0, wb_q});
        mul_b   = 33'(sn_q);
        state_d = S_ST_GO;
      end
      S_ST_GO: begin
        // 2*wb*sin / 2^14 against d in Q32
        c_req.start = 1'b1;
        c_y         = CW'(p_q >>> 13);
        c_x         = signed'({5'b0, d_q, 16'h0});
        state_d     = S_ST_WT;
      end
      S_ST_WT: begin
        if (c_done) begin
          state_d = (d_q <= {10'b0, la_q}) ? S_ADV : S_EMIT;
        end
      end
      S_ADV:    state_d = S_SR;
      S_SR: begin
        rd_addr = tidx_q;
        state_d = has_next ? S_SW : S_TGT;
      end
      S_SW:     state_d = S_D0;
      S_TGT: begin
        rd_addr = tidx_q;
        state_d = S_TGW;
      end
      S_TGW:    state_d = S_EMIT;
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      tidx_q      <= '0;
      loading_q   <= 1'b1;
      tx_q        <= '0;
      ty_q        <= '0;
      wb_q        <= WB_W'(196608);
      la_q        <= LA_W'(327680);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_WHEEL_BASE: wb_q <= cfg_data_i[WB_W-1:0];
          REG_LOOKAHEAD:  la_q <= cfg_data_i[LA_W-1:0];
          default: ;
        endcase
      end
      if (wr_en) begin
        total_q <= total_q + TW'(1);
      end
      if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INW: begin
          loading_q <= 1'b0;
          tx_q      <= (total_q != '0) ? rdx_q : 32'h0;
          ty_q      <= (total_q != '0) ? rdy_q : 32'h0;
        end
        S_ADV: if (has_next) tidx_q <= tidx_q + AW'(1);
        S_D3: begin
          if (sq_done && search_q && d_c < {10'b0, la_q}) begin
            tidx_q <= tidx_q + AW'(1);
          end
        end
        S_TGW: begin
          tx_q <= rdx_q;
          ty_q <= rdy_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[total_q[AW-1:0]] <= pos_x_i;
      mem_y[total_q[AW-1:0]] <= pos_y_i;
    end
    rdx_q <= mem_x[rd_addr];
    rdy_q <= mem_y[rd_addr];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (in_acc) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      qx_q <= quat_x_i;
      qy_q <= quat_y_i;
      qz_q <= quat_z_i;
      qw_q <= quat_w_i;
    end
    case (state_q)
      S_CHK:    brake_q <= brake_c;
      S_Q1:     acc1_q  <= p_q;
      S_Q2:     acc1_q  <= acc1_q + p_q;
      S_Q3:     acc2_q  <= p_q;
      S_Q4:     acc2_q  <= acc2_q + p_q;
      S_YAW_WT: begin
        if (c_done) begin
          yaw_q    <= c_z;
          dx_q     <= 33'(signed'(tx_q)) - 33'(px_q);
          dy_q     <= 33'(signed'(ty_q)) - 33'(py_q);
          search_q <= 1'b0;
        end
      end
      S_BR_WT:  if (c_done) alpha_q <= c_z - yaw_q;
      S_D1:     acc1_q <= p_q;
      S_D3:     if (sq_done) d_q <= d_c;
      S_SIN_WT: if (c_done) sn_q <= c_yo[31:0];
      S_ST_WT:  if (c_done) steer_q <= steer_c;
      S_SW: begin
        dx_q     <= 33'(signed'(rdx_q)) - 33'(px_q);
        dy_q     <= 33'(signed'(rdy_q)) - 33'(py_q);
        search_q <= 1'b1;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_steer_q <= brake_q ? 16'sd0 : steer_q;
          out_brake_q <= brake_q;
          out_slot_q  <= SLOT_W'(tidx_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign steer_o       = out_steer_q;
  assign brake_o       = out_brake_q;
  assign target_slot_o = out_slot_q;

  a_brake_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brake_o |-> steer_o == 16'sd0)
    else $error("braking result with nonzero steer");

  a_steer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (steer_o <= 16'sd16384) && (steer_o >= -16'sd16384))
    else $error("steer outside [-1,1]");

  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(WAYPOINT_DEPTH))
    else $error("waypoint count exceeds table depth");

  a_target_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !loading_q && (total_q != '0) |-> TW'(tidx_q) < total_q)
    else $error("target index beyond loaded waypoints");

endmodule

// ===== dv/ppst_steer_checker.sv =====
// Checker for the pure pursuit tracker: predicts each pose result and compares it.
module ppst_steer_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                command_i,
  input  logic signed [31:0]                  pos_x_i,
  input  logic signed [31:0]                  pos_y_i,
  input  logic signed [15:0]                  quat_x_i,
  input  logic signed [15:0]                  quat_y_i,
  input  logic signed [15:0]                  quat_z_i,
  input  logic signed [15:0]                  quat_w_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [15:0]                  steer_i,
  input  logic                                brake_i,
  input  logic [ppst_pkg::SLOT_W-1:0]         target_slot_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [ppst_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ppst_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  checked_o,
  output int                                  braked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppst_pkg::*;

  localparam int DEPTH  = WAYPOINT_DEPTH_DEF;
  localparam int MARGIN = END_MARGIN_DEF;
  localparam logic [31:0] ATAN_BRAD [0:30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001};

  typedef struct packed {
    logic signed [15:0]  steer;
    logic                brake;
    logic [SLOT_W-1:0]   slot;
  } steer_result_t;

  logic signed [31:0] path_x [DEPTH];
  logic signed [31:0] path_y [DEPTH];
  int                 path_len;
  int                 aim_idx;
  logic signed [31:0] aim_x, aim_y;
  logic               loading;
  logic [WB_W-1:0]    wb_reg;
  logic [LA_W-1:0]    lookahead;
  steer_result_t      expected_steer_q [$];

  function automatic logic [31:0] vec_atan2(longint y, longint x);
    logic [31:0] ang;
    longint mag, ay, sx, sy;
    ang = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h80000000;
    end
    ay = (y < 0) ? -y : y;
    mag = (x > ay) ? x : ay;
    while (mag < (64'sd1 <<< 49)) begin
      x = x * 2;
      y = y * 2;
      mag = mag * 2;
    end
    for (int i = 0; i < 31; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (y >= 0) begin
        x = x + sy; y = y - sx; ang = ang + ATAN_BRAD[i];
      end else begin
        x = x - sy; y = y + sx; ang = ang - ATAN_BRAD[i];
      end
    end
    return ang;
  endfunction

  function automatic longint rot_sin(logic [31:0] a);
    logic signed [31:0] t;
    longint s, x, y, sx, sy;
    t = a;
    s = t;
    if (s > (64'sd1 <<< 30) || s < -(64'sd1 <<< 30)) begin
      t = 32'h80000000 - a;
      s = t;
    end
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < 31; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (s >= 0) begin
        x = x - sy; y = y + sx; s = s - longint'(ATAN_BRAD[i]);
      end else begin
        x = x + sy; y = y - sx; s = s + longint'(ATAN_BRAD[i]);
      end
    end
    return y;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned span(longint dx, longint dy);
    longint unsigned ax, ay;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax < (64'd1 << 31) && ay < (64'd1 << 31)) return floor_sqrt(ax * ax + ay * ay);
    ax = ax >> 1;
    ay = ay >> 1;
    return 2 * floor_sqrt(ax * ax + ay * ay);
  endfunction

  // pose item: advances the target state and returns the steering result
  function automatic steer_result_t pursue_pose(longint px, longint py, longint qx,
                                                longint qy, longint qz, longint qw);
    steer_result_t res;
    logic [31:0] yaw, alpha, at;
    logic signed [31:0] at_s;
    longint dx, dy, sn, num, den, a, st;
    longint unsigned d;
    if (loading) begin
      loading = 1'b0;
      aim_x = (path_len != 0) ? path_x[0] : '0;
      aim_y = (path_len != 0) ? path_y[0] : '0;
    end
    if (path_len <= MARGIN || aim_idx >= path_len - MARGIN) begin
      res.steer = '0;
      res.brake = 1'b1;
      res.slot  = aim_idx[SLOT_W-1:0];
      return res;
    end
    yaw = vec_atan2(2 * (qw * qz + qx * qy), (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz));
    dx = aim_x - px;
    dy = aim_y - py;
    alpha = vec_atan2(dy, dx) - yaw;
    d = span(dx, dy);
    sn = rot_sin(alpha);
    num = (2 * longint'(wb_reg) * sn) >>> 14;
    den = longint'(d << 16);
    at = vec_atan2(num, den);
    at_s = at;
    a = at_s;
    st = -((a + 32768) >>> 16);
    if (st > 16384) st = 16384;
    if (st < -16384) st = -16384;
    if (d <= lookahead) begin
      if (aim_idx + 1 < path_len) aim_idx++;
      while (aim_idx + 1 < path_len &&
             span(path_x[aim_idx] - px, path_y[aim_idx] - py) < lookahead)
        aim_idx++;
      aim_x = path_x[aim_idx];
      aim_y = path_y[aim_idx];
    end
    res.steer = st[15:0];
    res.brake = 1'b0;
    res.slot  = aim_idx[SLOT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    steer_result_t exp_r;
    if (!rst_ni) begin
      path_len   = 0;
      aim_idx    = 0;
      aim_x      = '0;
      aim_y      = '0;
      loading    = 1'b1;
      wb_reg     = 20'd196608;
      lookahead  = 23'd327680;
      expected_steer_q.delete();
      fail_count_o <= 0;
      checked_o    <= 0;
      braked_o     <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_steer_q.size() == 0) begin
          $display("%0t: result with nothing expected: steer %0d brake %0d slot %0d",
                   $time, steer_i, brake_i, target_slot_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_steer_q.pop_front();
          checked_o <= checked_o + 1;
          if (exp_r.brake) braked_o <= braked_o + 1;
          if (exp_r.steer !== steer_i || exp_r.brake !== brake_i ||
              exp_r.slot !== target_slot_i) begin
            $display("%0t: mismatch expected steer %0d brake %0d slot %0d, got %0d %0d %0d",
                     $time, exp_r.steer, exp_r.brake, exp_r.slot,
                     steer_i, brake_i, target_slot_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (!command_i) begin
          if (loading && path_len < DEPTH) begin
            path_x[path_len] = pos_x_i;
            path_y[path_len] = pos_y_i;
            path_len++;
          end
        end else begin
          exp_r = pursue_pose(pos_x_i, pos_y_i, quat_x_i, quat_y_i, quat_z_i, quat_w_i);
          expected_steer_q.insert(expected_steer_q.size(), exp_r);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_WHEEL_BASE) wb_reg = cfg_data_i[WB_W-1:0];
        else if (cfg_index_i == REG_LOOKAHEAD) lookahead = cfg_data_i[LA_W-1:0];
      end
      pending_o <= expected_steer_q.size();
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Top of the pure pursuit tracker testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ppst_pkg::*;

  localparam int DEPTH = WAYPOINT_DEPTH_DEF;
  localparam int ROUTE_LEN = 300;
  localparam int PHASES = 6;
  localparam int POSES_PER_PHASE = 115;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0;
  logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] steer;
  logic brake;
  logic [SLOT_W-1:0] target_slot;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count, pending, checked, braked;
  int loads_sent = 0;
  logic calm = 1'b0;
  logic [SLOT_W-1:0] last_slot = '0;
  logic signed [31:0] route_x [DEPTH];
  logic signed [31:0] route_y [DEPTH];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pure_pursuit_steering_tracker dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .command_i(command),
    .pos_x_i(pos_x), .pos_y_i(pos_y),
    .quat_x_i(quat_x), .quat_y_i(quat_y), .quat_z_i(quat_z), .quat_w_i(quat_w),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .steer_o(steer), .brake_o(brake), .target_slot_o(target_slot),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  ppst_steer_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .command_i(command),
    .pos_x_i(pos_x), .pos_y_i(pos_y),
    .quat_x_i(quat_x), .quat_y_i(quat_y), .quat_z_i(quat_z), .quat_w_i(quat_w),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .steer_i(steer), .brake_i(brake), .target_slot_i(target_slot),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked), .braked_o(braked)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 15);
    if (out_valid && out_ready) last_slot <= target_slot;
  end

  // valid stays up after acceptance; the caller lowers it through idle_gap
  task automatic send_item(logic cmd, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw);
    in_valid <= 1'b1;
    command  <= cmd;
    pos_x    <= x;
    pos_y    <= y;
    quat_x   <= qx;
    quat_y   <= qy;
    quat_z   <= qz;
    quat_w   <= qw;
    do @(posedge clk); while (!in_ready);
    if (!cmd) loads_sent++;
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] any_quat();
    return 16'($urandom_range(32768)) - 16'sd16384;
  endfunction

  // hold off until every pose result is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    // let the count catch up with an item taken at this edge
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    logic signed [31:0] wx, wy, nx, ny;
    int s, r, n;
    logic [WB_W-1:0] wb_set [PHASES];
    logic [LA_W-1:0] la_set [PHASES];

    wb_set = '{20'd0, 20'd655360, 20'd196608, 20'd0, 20'd0, 20'd0};
    la_set = '{23'd0, 23'd327680, 23'd131072, 23'd0, 23'd0, 23'd6553600};
    wb_set[3] = WB_W'($urandom_range(655360));
    wb_set[4] = WB_W'($urandom_range(655360));
    wb_set[5] = WB_W'($urandom_range(655360));
    la_set[3] = LA_W'($urandom_range(1000000));
    la_set[4] = LA_W'($urandom_range(600000));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // path: a wandering line
    wx = $urandom_range(200000) - 100000;
    wy = $urandom_range(200000) - 100000;
    for (int i = 0; i < ROUTE_LEN; i++) begin
      route_x[i] = wx;
      route_y[i] = wy;
      send_item(1'b0, wx, wy, any_quat(), any_quat(), any_quat(), any_quat());
      idle_gap();
      wx = wx + $urandom_range(16384, 98304);
      wy = wy + $urandom_range(65536) - 32768;
    end

    // directed poses and late loads at the default settings
    send_item(1'b1, route_x[0], route_y[0], 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_item(1'b1, route_x[0] - 32'sd100000, route_y[0], 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_item(1'b1, route_x[0], route_y[0] + 32'sd70000, -16'sd16384, 16'sd16384, 16'sd0, 16'sd0);
    send_item(1'b1, route_x[0], route_y[0], 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b1, route_x[1], route_y[1], -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_item(1'b1, 32'sh80000000, 32'sh7FFFFFFF, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_item(1'b1, 32'sh7FFFFFFF, 32'sh80000000, 16'sd0, 16'sd16384, 16'sd0, -16'sd16384);
    send_item(1'b0, 32'sh12345678, -32'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b1, route_x[2], route_y[2], 16'sd0, 16'sd0, 16'sd11585, 16'sd11585);
    send_item(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_WHEEL_BASE, CFG_DATA_W'(wb_set[ph]));
      write_reg(REG_LOOKAHEAD, la_set[ph]);
      calm = (ph == 2);
      n = 0;
      while (n < POSES_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 8) begin
          // late load, dropped by the block
          send_item(1'b0, $urandom(), $urandom(), any_quat(), any_quat(), any_quat(),
                    any_quat());
        end else begin
          n++;
          if (r < 15) begin
            nx = $urandom();
            ny = $urandom();
          end else if (r < 20) begin
            nx = route_x[last_slot];
            ny = route_y[last_slot];
          end else begin
            s = last_slot + $urandom_range(4);
            if (s > ROUTE_LEN - 1) s = ROUTE_LEN - 1;
            nx = route_x[s] + ($urandom_range(40000) - 20000);
            ny = route_y[s] + ($urandom_range(40000) - 20000);
          end
          send_item(1'b1, nx, ny, any_quat(), any_quat(), any_quat(), any_quat());
        end
        idle_gap();
      end
    end

    drain();
    $display("run covered %0d pose results (%0d braking) after %0d loads,", checked, braked,
             loads_sent);
    $display("over %0d register settings from zero to full scale", PHASES + 1);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/ppst_pkg.sv
sv/ppst_cordic.sv
sv/ppst_isqrt.sv
sv/pure_pursuit_steering_tracker.sv
dv/ppst_steer_checker.sv
dv/tb_top.sv
